// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside reset.
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every rising edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/pdcms_pkg.sv =====
package pdcms_pkg;

  localparam int CNT_W = 16;
  localparam int LIM_W = (CNT_W > 16) ? CNT_W : 16;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_CMD     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;
  localparam logic [7:0]  CMD_RESET     = 8'hA2;
  localparam logic [15:0] TIMEOUT_RESET = 16'd10;

  localparam logic [7:0] CRC_POLY  = 8'h37;
  localparam logic [7:0] SEAL_MASK = 8'hFC;
  localparam logic [7:0] SEAL_SET  = 8'h01;

  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_RX_BYTE = 2'd1;
  localparam logic [1:0] OP_TX_FAIL = 2'd2;
  localparam logic [1:0] OP_TICK    = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_CHECK   = 2'd2;

  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic       driver_enable;
    logic [1:0] status;
    logic [7:0] pd_in;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic       is_report;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [1:0] status;
  } job_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] seal(input logic [7:0] crc);
    return (crc & SEAL_MASK) | SEAL_SET;
  endfunction

endpackage

// ===== src/pdcms_front.sv =====
module pdcms_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pdcms_pkg::in_word_t                 in_word,
  input  logic                                cfg_wr_en,
  input  logic [pdcms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pdcms_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                                q_full,
  output logic                                q_push,
  output pdcms_pkg::job_t                     q_job
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_FIRST  = 3'b010,
    PH_SECOND = 3'b100
  } phase_t;

  phase_t                       phase_r, phase_nxt;
  logic [pdcms_pkg::CNT_W-1:0]  wait_r, wait_nxt;
  logic [pdcms_pkg::CNT_W-1:0]  wait_inc;
  logic [7:0]                   held_r, held_nxt;
  logic [7:0]                   held_chk_r, held_chk_nxt;
  logic [7:0]                   cmd_r;
  logic [15:0]                  timeout_r;
  logic                         accept;
  logic                         waiting;
  logic                         tick_expired;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign waiting  = (phase_r == PH_FIRST) || (phase_r == PH_SECOND);

  assign wait_inc = (wait_r == pdcms_pkg::CNT_MAX) ? wait_r
                                                   : wait_r + pdcms_pkg::CNT_W'(1);
  assign tick_expired = (pdcms_pkg::LIM_W'(wait_inc) >= pdcms_pkg::LIM_W'(timeout_r)) ||
                        (wait_inc == pdcms_pkg::CNT_MAX);

  always_comb begin
    phase_nxt    = phase_r;
    wait_nxt     = wait_r;
    held_nxt     = held_r;
    held_chk_nxt = held_chk_r;
    q_push       = 1'b0;
    q_job        = '0;
    if (accept) begin
      case (in_word.operation)
        pdcms_pkg::OP_START: begin
          if (!waiting) begin
            q_push       = 1'b1;
            q_job.byte_a = cmd_r;
            q_job.byte_b = in_word.data_byte;
            phase_nxt    = PH_FIRST;
            wait_nxt     = '0;
          end
        end
        pdcms_pkg::OP_RX_BYTE: begin
          case (phase_r)
            PH_FIRST: begin
              held_nxt     = in_word.data_byte;
              held_chk_nxt = pdcms_pkg::seal(pdcms_pkg::crc8_byte(8'h00, in_word.data_byte));
              phase_nxt    = PH_SECOND;
            end
            PH_SECOND: begin
              q_push          = 1'b1;
              q_job.is_report = 1'b1;
              if (in_word.data_byte == held_chk_r) begin
                q_job.status = pdcms_pkg::ST_OK;
                q_job.byte_a = held_r;
              end else begin
                q_job.status = pdcms_pkg::ST_CHECK;
              end
              phase_nxt = PH_IDLE;
            end
            default: begin
            end
          endcase
        end
        pdcms_pkg::OP_TX_FAIL: begin
          if (waiting) begin
            q_push          = 1'b1;
            q_job.is_report = 1'b1;
            q_job.status    = pdcms_pkg::ST_TIMEOUT;
            phase_nxt       = PH_IDLE;
          end
        end
        default: begin
          if (waiting) begin
            wait_nxt = wait_inc;
            if (tick_expired) begin
              q_push          = 1'b1;
              q_job.is_report = 1'b1;
              q_job.status    = pdcms_pkg::ST_TIMEOUT;
              phase_nxt       = PH_IDLE;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      wait_r    <= '0;
      cmd_r     <= pdcms_pkg::CMD_RESET;
      timeout_r <= pdcms_pkg::TIMEOUT_RESET;
    end else begin
      phase_r <= phase_nxt;
      wait_r  <= wait_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          pdcms_pkg::CFG_CMD:     cmd_r     <= cfg_wdata[7:0];
          pdcms_pkg::CFG_TIMEOUT: timeout_r <= cfg_wdata[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    held_r     <= held_nxt;
    held_chk_r <= held_chk_nxt;
  end

endmodule

// ===== src/pdcms_queue.sv =====
module pdcms_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pdcms_pkg::job_t push_job,
  input  logic            pop,
  output pdcms_pkg::job_t head_job,
  output logic            full,
  output logic            not_empty
);

  pdcms_pkg::job_t                store_r [pdcms_pkg::QDEPTH];
  logic [pdcms_pkg::QAW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [pdcms_pkg::QAW:0]        cnt_r;

  assign full      = (cnt_r == (pdcms_pkg::QAW+1)'(pdcms_pkg::QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_job  = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + pdcms_pkg::QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + pdcms_pkg::QAW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (pdcms_pkg::QAW+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (pdcms_pkg::QAW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== src/pdcms_back.sv =====
module pdcms_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_not_empty,
  input  pdcms_pkg::job_t       q_job,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pdcms_pkg::out_word_t  out_word
);

  typedef enum logic [2:0] {
    BK_IDLE  = 3'b001,
    BK_DATA  = 3'b010,
    BK_CHECK = 3'b100
  } seq_t;

  seq_t                 seq_r, seq_nxt;
  logic [7:0]           crc_r, crc_nxt;
  logic [7:0]           data_r, data_nxt;
  logic                 out_valid_r, out_valid_nxt;
  pdcms_pkg::out_word_t out_word_r, out_word_nxt;
  logic                 free;
  logic                 load;

  assign free      = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    seq_nxt                    = seq_r;
    crc_nxt                    = crc_r;
    data_nxt                   = data_r;
    out_word_nxt               = out_word_r;
    load                       = 1'b0;
    q_pop                      = 1'b0;
    case (seq_r)
      BK_IDLE: begin
        if (free && q_not_empty) begin
          q_pop = 1'b1;
          load  = 1'b1;
          out_word_nxt = '0;
          if (q_job.is_report) begin
            out_word_nxt.kind   = pdcms_pkg::KIND_REPORT;
            out_word_nxt.status = q_job.status;
            out_word_nxt.pd_in  = q_job.byte_a;
            out_word_nxt.last   = 1'b1;
          end else begin
            out_word_nxt.kind          = pdcms_pkg::KIND_TX;
            out_word_nxt.tx_byte       = q_job.byte_a;
            out_word_nxt.driver_enable = 1'b1;
            crc_nxt  = pdcms_pkg::crc8_byte(8'h00, q_job.byte_a);
            data_nxt = q_job.byte_b;
            seq_nxt  = BK_DATA;
          end
        end
      end
      BK_DATA: begin
        if (free) begin
          load         = 1'b1;
          out_word_nxt = '0;
          out_word_nxt.kind          = pdcms_pkg::KIND_TX;
          out_word_nxt.tx_byte       = data_r;
          out_word_nxt.driver_enable = 1'b1;
          crc_nxt = pdcms_pkg::crc8_byte(crc_r, data_r);
          seq_nxt = BK_CHECK;
        end
      end
      BK_CHECK: begin
        if (free) begin
          load         = 1'b1;
          out_word_nxt = '0;
          out_word_nxt.kind          = pdcms_pkg::KIND_TX;
          out_word_nxt.tx_byte       = pdcms_pkg::seal(crc_r);
          out_word_nxt.driver_enable = 1'b1;
          out_word_nxt.last          = 1'b1;
          seq_nxt = BK_IDLE;
        end
      end
      default: begin
        seq_nxt = BK_IDLE;
      end
    endcase
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r      <= crc_nxt;
    data_r     <= data_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

// ===== src/pd_cycle_master_sequencer_unit.sv =====
// A job from an accepted word passes through the queue into the output register.
// A start gives three frame words, sent in order by the frame sequencer; out_stall can
// hold each one, and the sequencer takes its next job only after the last is loaded.
// A two-entry queue parts the event decoder from the frame sequencer.
// Reset is synchronous, active low: phase idle, tick count zero, queue empty,
// command 0xA2 and reply timeout 10 ticks.
module pd_cycle_master_sequencer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  pdcms_pkg::in_word_t               in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output pdcms_pkg::out_word_t              out_word,
  input  logic                              cfg_wr_en,
  input  logic [pdcms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pdcms_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  pdcms_pkg::job_t push_job;
  pdcms_pkg::job_t head_job;
  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_not_empty;

  pdcms_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  pdcms_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .pop       (q_pop),
    .head_job  (head_job),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  pdcms_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_job       (head_job),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word)
  );

endmodule

// ===== src/pdcms_checker.sv =====
`include "assert_macros.svh"

module pdcms_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input pdcms_pkg::out_word_t out_word
);

  `CHK_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_word), "stalled word changed")
  `CHK_ASSERT(a_report_shape, out_valid && out_word.kind == pdcms_pkg::KIND_REPORT |-> !out_word.driver_enable && out_word.tx_byte == 8'h00 && out_word.last, "malformed report")
  `CHK_ASSERT(a_tx_shape, out_valid && out_word.kind == pdcms_pkg::KIND_TX |-> out_word.driver_enable && out_word.status == pdcms_pkg::ST_OK && out_word.pd_in == 8'h00, "malformed frame word")
  `CHK_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_valid && !in_stall, "reset left state behind")

endmodule

bind pd_cycle_master_sequencer_unit pdcms_checker u_pdcms_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

// ===== tb/sv/tb_pd_cycle_master_sequencer_unit.sv =====
`timescale 1ns / 1ps

module tb_pd_cycle_master_sequencer_unit;

  localparam int HALF_PERIOD = 6;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_WORDS = 72;

  typedef enum logic [2:0] {
    LINE_IDLE   = 3'b001,
    AWAIT_DATA  = 3'b010,
    AWAIT_CHECK = 3'b100
  } seq_phase_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  pdcms_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pdcms_pkg::out_word_t out_word;
  logic cfg_wr_en = 1'b0;
  logic [pdcms_pkg::CFG_IDX_W-1:0] cfg_index = pdcms_pkg::CFG_CMD;
  logic [pdcms_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  pd_cycle_master_sequencer_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  pdcms_pkg::in_word_t line_events[$];
  pdcms_pkg::out_word_t due_words[$];

  // mirror of the sequencer
  logic [7:0] command_octet = pdcms_pkg::CMD_RESET;
  logic [15:0] reply_limit = pdcms_pkg::TIMEOUT_RESET;
  seq_phase_t seq_phase = LINE_IDLE;
  logic [7:0] held_data;
  logic [pdcms_pkg::CNT_W-1:0] ticks_seen = '0;

  int words_queued = 0;
  int words_taken = 0;
  int frames_sent = 0;
  int reports_ok = 0;
  int reports_timeout = 0;
  int reports_check = 0;
  int settings_used = 0;
  int mismatches = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_pct = 0;
  int stall_age = 0;
  int quiet_cycles = 0;

  function automatic logic [7:0] crc37(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ pdcms_pkg::CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [7:0] sealed_check(input logic [7:0] c);
    return (c & pdcms_pkg::SEAL_MASK) | pdcms_pkg::SEAL_SET;
  endfunction

  function automatic pdcms_pkg::out_word_t make_word(input logic kind, input logic [7:0] tx,
                                                     input logic de, input logic [1:0] st,
                                                     input logic [7:0] pd, input logic last);
    pdcms_pkg::out_word_t w;
    w.kind = kind;
    w.tx_byte = tx;
    w.driver_enable = de;
    w.status = st;
    w.pd_in = pd;
    w.last = last;
    return w;
  endfunction

  task automatic close_cycle(input logic [1:0] st, input logic [7:0] pd);
    due_words.push_back(make_word(pdcms_pkg::KIND_REPORT, 8'h00, 1'b0, st, pd, 1'b1));
    seq_phase = LINE_IDLE;
    case (st)
      pdcms_pkg::ST_OK: reports_ok++;
      pdcms_pkg::ST_TIMEOUT: reports_timeout++;
      default: reports_check++;
    endcase
  endtask

  task automatic advance_master(input pdcms_pkg::in_word_t w);
    logic waiting;
    logic [pdcms_pkg::LIM_W-1:0] lim;
    waiting = (seq_phase == AWAIT_DATA) || (seq_phase == AWAIT_CHECK);
    case (w.operation)
      pdcms_pkg::OP_START: begin
        if (!waiting) begin
          due_words.push_back(make_word(pdcms_pkg::KIND_TX, command_octet, 1'b1,
                                        pdcms_pkg::ST_OK, 8'h00, 1'b0));
          due_words.push_back(make_word(pdcms_pkg::KIND_TX, w.data_byte, 1'b1,
                                        pdcms_pkg::ST_OK, 8'h00, 1'b0));
          due_words.push_back(make_word(pdcms_pkg::KIND_TX,
                                        sealed_check(crc37(crc37(8'h00, command_octet),
                                                           w.data_byte)),
                                        1'b1, pdcms_pkg::ST_OK, 8'h00, 1'b1));
          seq_phase = AWAIT_DATA;
          ticks_seen = '0;
          frames_sent++;
        end
      end
      pdcms_pkg::OP_RX_BYTE: begin
        if (seq_phase == AWAIT_DATA) begin
          held_data = w.data_byte;
          seq_phase = AWAIT_CHECK;
        end else if (seq_phase == AWAIT_CHECK) begin
          if (w.data_byte == sealed_check(crc37(8'h00, held_data))) begin
            close_cycle(pdcms_pkg::ST_OK, held_data);
          end else begin
            close_cycle(pdcms_pkg::ST_CHECK, 8'h00);
          end
        end
      end
      pdcms_pkg::OP_TX_FAIL: begin
        if (waiting) close_cycle(pdcms_pkg::ST_TIMEOUT, 8'h00);
      end
      default: begin
        if (waiting) begin
          lim = reply_limit;
          if (lim > pdcms_pkg::CNT_MAX) lim = pdcms_pkg::CNT_MAX;
          if (ticks_seen != pdcms_pkg::CNT_MAX) ticks_seen++;
          if (ticks_seen >= lim) close_cycle(pdcms_pkg::ST_TIMEOUT, 8'h00);
        end
      end
    endcase
  endtask

  task automatic note_mismatch(input string what, input int want, input int got);
    $display("mismatch on %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $time);
    mismatches++;
  endtask

  // driver: bursts with gaps, payload held while stalled
  always @(posedge clk) begin : drive
    logic nv;
    pdcms_pkg::in_word_t nw;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nv = in_valid;
      nw = in_word;
      if (in_valid && !in_stall) begin
        advance_master(in_word);
        words_taken++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (line_events.size() > 0) begin
          nw = line_events.pop_front();
          nv = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      in_valid <= nv;
      in_word <= nw;
    end
  end

  // receiver stall pattern: stall percentage redrawn whenever stall_age wraps
  always @(posedge clk) begin
    if (stall_age == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 80;
      endcase
    end
    stall_age = (stall_age + 1) % 128;
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin : monitor
    pdcms_pkg::out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (due_words.size() == 0) begin
        note_mismatch("unexpected word", 0, int'(out_word));
      end else begin
        e = due_words.pop_front();
        if (out_word.kind !== e.kind) note_mismatch("kind", e.kind, out_word.kind);
        if (out_word.tx_byte !== e.tx_byte) note_mismatch("tx_byte", e.tx_byte, out_word.tx_byte);
        if (out_word.driver_enable !== e.driver_enable)
          note_mismatch("driver_enable", e.driver_enable, out_word.driver_enable);
        if (out_word.status !== e.status) note_mismatch("status", e.status, out_word.status);
        if (out_word.pd_in !== e.pd_in) note_mismatch("pd_in", e.pd_in, out_word.pd_in);
        if (out_word.last !== e.last) note_mismatch("last", e.last, out_word.last);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("no progress for %0d cycles, %0d words still due", quiet_cycles,
                 due_words.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic push_item(input logic [1:0] op, input logic [7:0] b);
    pdcms_pkg::in_word_t w;
    w.operation = op;
    w.data_byte = b;
    line_events.push_back(w);
    words_queued++;
  endtask

  task automatic settle();
    do @(negedge clk); while (line_events.size() != 0 || in_valid || due_words.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_regs(input logic [7:0] cmd, input logic [15:0] limit);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= pdcms_pkg::CFG_CMD;
    cfg_wdata <= pdcms_pkg::CFG_DATA_W'(cmd);
    command_octet = cmd;
    @(posedge clk);
    cfg_index <= pdcms_pkg::CFG_TIMEOUT;
    cfg_wdata <= pdcms_pkg::CFG_DATA_W'(limit);
    reply_limit = limit;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  task automatic gen_exchange();
    logic [7:0] b1;
    int r;
    b1 = 8'($urandom);
    if ($urandom_range(0, 99) < 12) begin
      push_item(2'($urandom_range(0, 3)), 8'($urandom));
    end else begin
      push_item(pdcms_pkg::OP_START, 8'($urandom));
      if ($urandom_range(0, 4) == 0) push_item(pdcms_pkg::OP_START, 8'($urandom));
      repeat ($urandom_range(0, 2)) push_item(pdcms_pkg::OP_TICK, 8'($urandom));
      r = $urandom_range(0, 99);
      if (r < 60) begin
        push_item(pdcms_pkg::OP_RX_BYTE, b1);
        repeat ($urandom_range(0, 2)) push_item(pdcms_pkg::OP_TICK, 8'($urandom));
        if ($urandom_range(0, 4) != 0) begin
          push_item(pdcms_pkg::OP_RX_BYTE, sealed_check(crc37(8'h00, b1)));
        end else begin
          push_item(pdcms_pkg::OP_RX_BYTE, 8'($urandom));
        end
      end else if (r < 75) begin
        if ($urandom_range(0, 1) == 1) push_item(pdcms_pkg::OP_RX_BYTE, b1);
        push_item(pdcms_pkg::OP_TX_FAIL, 8'($urandom));
      end else if (r < 92 && reply_limit <= 40) begin
        repeat ((reply_limit == 0) ? 1 : reply_limit)
          push_item(pdcms_pkg::OP_TICK, 8'($urandom));
      end else if (r < 92) begin
        push_item(pdcms_pkg::OP_TX_FAIL, 8'($urandom));
      end else begin
        // drop the reply half way
        push_item(pdcms_pkg::OP_RX_BYTE, b1);
      end
    end
  endtask

  initial begin : stimulus
    int base;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    push_item(pdcms_pkg::OP_TICK, 8'h00);
    push_item(pdcms_pkg::OP_RX_BYTE, 8'hFF);
    push_item(pdcms_pkg::OP_TX_FAIL, 8'h55);
    push_item(pdcms_pkg::OP_START, 8'h00);
    push_item(pdcms_pkg::OP_RX_BYTE, 8'hFF);
    push_item(pdcms_pkg::OP_RX_BYTE, sealed_check(crc37(8'h00, 8'hFF)));
    push_item(pdcms_pkg::OP_START, 8'hFF);
    push_item(pdcms_pkg::OP_RX_BYTE, 8'h00);
    push_item(pdcms_pkg::OP_RX_BYTE, ~sealed_check(crc37(8'h00, 8'h00)));
    push_item(pdcms_pkg::OP_START, 8'h5A);
    push_item(pdcms_pkg::OP_START, 8'h3C);
    push_item(pdcms_pkg::OP_RX_BYTE, 8'h81);
    push_item(pdcms_pkg::OP_TX_FAIL, 8'hAA);
    push_item(pdcms_pkg::OP_START, 8'hA5);
    repeat (4) push_item(pdcms_pkg::OP_TICK, 8'h0F);
    push_item(pdcms_pkg::OP_RX_BYTE, 8'h7E);
    repeat (6) push_item(pdcms_pkg::OP_TICK, 8'hF0);
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_regs(8'($urandom), 16'd0);
        1: set_regs(8'hFF, 16'd1);
        2: set_regs(8'h00, 16'hFFFF);
        3: set_regs(8'($urandom), 16'($urandom_range(2, 12)));
        4: set_regs(8'($urandom), 16'($urandom_range(1, 40)));
        default: set_regs(8'($urandom), 16'hFFFF);
      endcase
      base = words_queued;
      while (words_queued - base < PHASE_WORDS) gen_exchange();
      settle();
    end

    $display("%0d line events taken, %0d frames sent; reports ok %0d, timeout %0d, check %0d",
             words_taken, frames_sent, reports_ok, reports_timeout, reports_check);
    $display("%0d register settings, reply limits 0, 1, small and 65535 ticks", settings_used);
    if (mismatches == 0 && due_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
